// ----- src/median3_outlier_range_qualifier_core_macros.svh -----
// Assertion macros shared by the median-of-three qualifier RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef MEDIAN3_OUTLIER_RANGE_QUALIFIER_CORE_MACROS_SVH
`define MEDIAN3_OUTLIER_RANGE_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define M3OQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3oq check failed");

// Next-cycle implication, checked outside reset.
`define M3OQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3oq check failed");

`endif

// ----- src/m3oq_pkg.sv -----
// Package for the median-of-three outlier qualifier: payload types,
// disposition codes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package m3oq_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned HIST_DEPTH = 3;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_OUTLIER_LIMIT = 16'd50;
  localparam logic [CFG_W-1:0] RST_WIN_A_LOW     = 16'd495;
  localparam logic [CFG_W-1:0] RST_WIN_A_HIGH    = 16'd505;
  localparam logic [CFG_W-1:0] RST_WIN_B_LOW     = 16'd295;
  localparam logic [CFG_W-1:0] RST_WIN_B_HIGH    = 16'd305;

  localparam logic [1:0] FILL_FULL = 2'd3;

  typedef enum logic [2:0] {
    DISP_ZERO    = 3'd0,
    DISP_OUTLIER = 3'd1,
    DISP_WIN_A   = 3'd2,
    DISP_WIN_B   = 3'd3,
    DISP_OUTSIDE = 3'd4
  } disp_t;

  typedef enum logic [2:0] {
    REG_OUTLIER_LIMIT = 3'd0,
    REG_WIN_A_LOW     = 3'd1,
    REG_WIN_A_HIGH    = 3'd2,
    REG_WIN_B_LOW     = 3'd3,
    REG_WIN_B_HIGH    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] distance_sample;
  } sample_t;

  typedef struct packed {
    disp_t               disposition;
    logic                indicator_on;
    logic [SAMPLE_W-1:0] reference_median;
    logic [COUNT_W-1:0]  in_window_total;
    logic [COUNT_W-1:0]  zero_total;
    logic [COUNT_W-1:0]  outlier_total;
  } result_t;

endpackage

`default_nettype wire

// ----- src/m3oq_chan_if.sv -----
// Valid/ready channel interface used for the sample and result streams.
// Payload type is set per instance; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface m3oq_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/median3_outlier_range_qualifier_core.sv -----
// Median-of-three outlier qualifier for distance samples.
// Uses m3oq_pkg, the m3oq_chan_if channel interface and the assertion macros.
//
// Usage:
//   in_ch  (sink, payload m3oq_pkg::sample_t) carries one distance sample
//          per request. out_ch (source, payload m3oq_pkg::result_t) returns
//          exactly one result per accepted sample, in order.
//   cfg_*  is an APB-style write/read port for the limit and the two
//          windows (byte address 4 * register index, pready always high).
//          Write registers only while no sample is in flight.
// Timing:
//   A sample is captured into an input register, then judged against the
//   history and the windows into the result register, which drives out_ch.
//   One sample per cycle is sustained while out_ch.ready stays high; the
//   judge is combinational and the history updates as the result registers.
// Reset (rst_n low, synchronous) empties both stages, clears the history
// and counters and loads the default limit and windows.
// When out_ch.ready is low the result register holds, the input register
// holds its sample behind it, and in_ch.ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none
`include "median3_outlier_range_qualifier_core_macros.svh"

module median3_outlier_range_qualifier_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  m3oq_chan_if.sink                               in_ch,
  m3oq_chan_if.source                             out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [m3oq_pkg::ADDR_W-1:0]        cfg_paddr,
  input  wire logic [m3oq_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic      [m3oq_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int unsigned SW = m3oq_pkg::SAMPLE_W;
  localparam int unsigned CW = m3oq_pkg::COUNT_W;
  localparam int unsigned RW = m3oq_pkg::CFG_W;

  // Configuration registers.
  logic [RW-1:0] limit_r, wa_lo_r, wa_hi_r, wb_lo_r, wb_hi_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  // Pipeline registers.
  logic                 s1_valid_r;
  logic [SW-1:0]        s1_sample_r;
  logic                 out_valid_r;
  m3oq_pkg::result_t    out_r, out_nxt;
  logic                 s1_adv, in_fire;

  // History and counters.
  logic [SW-1:0] hist_r [m3oq_pkg::HIST_DEPTH];
  logic [1:0]    fill_r, fill_nxt;
  logic [CW-1:0] win_cnt_r, win_cnt_nxt;
  logic [CW-1:0] zero_cnt_r, zero_cnt_nxt;
  logic [CW-1:0] outl_cnt_r, outl_cnt_nxt;
  logic          hist_push;

  // Judge intermediates.
  logic          full;
  logic [SW-1:0] lo_ab, hi_ab, med, diff;
  logic          in_a, in_b;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  // Register write decode; writes to unused addresses are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= m3oq_pkg::RST_OUTLIER_LIMIT;
      wa_lo_r <= m3oq_pkg::RST_WIN_A_LOW;
      wa_hi_r <= m3oq_pkg::RST_WIN_A_HIGH;
      wb_lo_r <= m3oq_pkg::RST_WIN_B_LOW;
      wb_hi_r <= m3oq_pkg::RST_WIN_B_HIGH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        m3oq_pkg::REG_OUTLIER_LIMIT: limit_r <= cfg_pwdata[RW-1:0];
        m3oq_pkg::REG_WIN_A_LOW:     wa_lo_r <= cfg_pwdata[RW-1:0];
        m3oq_pkg::REG_WIN_A_HIGH:    wa_hi_r <= cfg_pwdata[RW-1:0];
        m3oq_pkg::REG_WIN_B_LOW:     wb_lo_r <= cfg_pwdata[RW-1:0];
        m3oq_pkg::REG_WIN_B_HIGH:    wb_hi_r <= cfg_pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    unique case (cfg_idx)
      m3oq_pkg::REG_OUTLIER_LIMIT: cfg_prdata = {{(32-RW){1'b0}}, limit_r};
      m3oq_pkg::REG_WIN_A_LOW:     cfg_prdata = {{(32-RW){1'b0}}, wa_lo_r};
      m3oq_pkg::REG_WIN_A_HIGH:    cfg_prdata = {{(32-RW){1'b0}}, wa_hi_r};
      m3oq_pkg::REG_WIN_B_LOW:     cfg_prdata = {{(32-RW){1'b0}}, wb_lo_r};
      m3oq_pkg::REG_WIN_B_HIGH:    cfg_prdata = {{(32-RW){1'b0}}, wb_hi_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // Handshake: the judge stage moves when the result register is free
  // or being drained this cycle.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // Median of the held history (zero until full), the input's distance from it and its window membership.
  always_comb begin
    full  = (fill_r == m3oq_pkg::FILL_FULL);
    lo_ab = (hist_r[0] < hist_r[1]) ? hist_r[0] : hist_r[1];
    hi_ab = (hist_r[0] > hist_r[1]) ? hist_r[0] : hist_r[1];
    med   = '0;
    if (full) begin
      med = (hi_ab < hist_r[2]) ? hi_ab : hist_r[2];
      med = (lo_ab > med) ? lo_ab : med;
    end
    diff = (s1_sample_r > med) ? (s1_sample_r - med) : (med - s1_sample_r);
    in_a = (s1_sample_r >= wa_lo_r) && (s1_sample_r <= wa_hi_r);
    in_b = (s1_sample_r >= wb_lo_r) && (s1_sample_r <= wb_hi_r);
  end

  // Disposition, counter and history updates for the sample in stage one.
  always_comb begin
    win_cnt_nxt  = win_cnt_r;
    zero_cnt_nxt = zero_cnt_r;
    outl_cnt_nxt = outl_cnt_r;
    fill_nxt     = fill_r;
    hist_push    = 1'b0;
    out_nxt.indicator_on = 1'b0;
    priority if (s1_sample_r == '0) begin
      out_nxt.disposition = m3oq_pkg::DISP_ZERO;
      if (zero_cnt_r != '1) zero_cnt_nxt = zero_cnt_r + 1'b1;
    end else if (full && (diff > limit_r)) begin
      out_nxt.disposition = m3oq_pkg::DISP_OUTLIER;
      if (outl_cnt_r != '1) outl_cnt_nxt = outl_cnt_r + 1'b1;
    end else begin
      hist_push = 1'b1;
      if (!full) fill_nxt = fill_r + 2'd1;
      priority if (in_a) out_nxt.disposition = m3oq_pkg::DISP_WIN_A;
      else if (in_b)     out_nxt.disposition = m3oq_pkg::DISP_WIN_B;
      else               out_nxt.disposition = m3oq_pkg::DISP_OUTSIDE;
      if (in_a || in_b) begin
        out_nxt.indicator_on = 1'b1;
        if (win_cnt_r != '1) win_cnt_nxt = win_cnt_r + 1'b1;
      end
    end
    out_nxt.reference_median = med;
    out_nxt.in_window_total  = win_cnt_nxt;
    out_nxt.zero_total       = zero_cnt_nxt;
    out_nxt.outlier_total    = outl_cnt_nxt;
  end

  // Control state: stage valids, fill level, counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      win_cnt_r   <= '0;
      zero_cnt_r  <= '0;
      outl_cnt_r  <= '0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_adv) out_valid_r <= s1_valid_r;
      if (s1_adv && s1_valid_r) begin
        fill_r     <= fill_nxt;
        win_cnt_r  <= win_cnt_nxt;
        zero_cnt_r <= zero_cnt_nxt;
        outl_cnt_r <= outl_cnt_nxt;
      end
    end
  end

  // History shift line; reset to zeros as specified.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0] <= '0;
      hist_r[1] <= '0;
      hist_r[2] <= '0;
    end else if (s1_adv && s1_valid_r && hist_push) begin
      hist_r[2] <= hist_r[1];
      hist_r[1] <= hist_r[0];
      hist_r[0] <= s1_sample_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) s1_sample_r <= in_ch.payload.distance_sample;
    if (s1_adv && s1_valid_r) out_r <= out_nxt;
  end

  // Checks on the judge stage.
  `M3OQ_ASSERT_NEXT(a_short_hist_no_median, clk, rst_n, s1_adv && s1_valid_r && !full, out_r.reference_median == '0 && out_r.disposition != m3oq_pkg::DISP_OUTLIER)
  `M3OQ_ASSERT_NOW(a_zero_counted, clk, rst_n, out_valid_r && out_r.disposition == m3oq_pkg::DISP_ZERO, out_r.zero_total != '0)
  `M3OQ_ASSERT_NOW(a_indicator_matches, clk, rst_n, out_valid_r, out_r.indicator_on == (out_r.disposition == m3oq_pkg::DISP_WIN_A || out_r.disposition == m3oq_pkg::DISP_WIN_B))
  `M3OQ_ASSERT_NEXT(a_push_newest, clk, rst_n, s1_adv && s1_valid_r && hist_push, hist_r[0] == $past(s1_sample_r))

endmodule

`default_nettype wire
